// ===== sv/srs_pkg.sv =====
package srs_pkg;

  localparam int unsigned QDepth = 4;

  localparam logic [1:0] CfgWidthMode = 2'd0;
  localparam logic [1:0] CfgColorMode = 2'd1;

  typedef struct packed {
    logic [15:0] pixel;
    logic        twice;
    logic        done_first;
    logic        done_second;
  } srs_entry_t;

endpackage

// ===== sv/scanline_pixel_rescaler.sv =====
// Horizontal nearest-neighbour rescaler: one source pixel in, zero to two
// RGB565 pixels out, building a line of OutWidth output pixels.
// Input side: present word15_i, red_i, green_i, blue_i and line_end_i with
// push high; the item is taken at a clock edge where full is low.
// Result side: pixel_o and line_done_o show the oldest result while empty
// is low; pop takes it at a clock edge where empty is low.
// Configuration: cfg_we_i with cfg_addr_i 0 writes the width mode, 1 the
// colour mode; write only while no item is in flight.
// Results pass through the queue and then the output register before they
// show on the ports. Throughput: one item per cycle on the input while full
// is low; the result register delivers one result per cycle while the
// receiver pops, so a doubled pixel occupies it twice, absorbed by the
// four-entry queue between classifier and output stage.
// Receiver stall: results wait in the output register and the queue; once
// the queue fills, full rises and input stops.
// Reset: width mode 320, colour mode 15-bit, counters cleared but the
// mod-18 phase preset to 14, queue and output empty.
module scanline_pixel_rescaler #(
  parameter int unsigned OutWidth = 320
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [15:0] word15_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        line_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] pixel_o,
  output logic        line_done_o
);

  logic                q_wr;
  logic                q_rd;
  logic                q_full;
  logic                q_empty;
  srs_pkg::srs_entry_t wr_entry;
  srs_pkg::srs_entry_t rd_entry;

  assign full = q_full;

  srs_front #(
    .OutWidth(OutWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .q_full_i   (q_full),
    .word15_i   (word15_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .line_end_i (line_end_i),
    .q_wr_o     (q_wr),
    .q_entry_o  (wr_entry)
  );

  srs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_entry_i(wr_entry),
    .rd_i      (q_rd),
    .rd_entry_o(rd_entry),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  srs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_entry_i  (rd_entry),
    .q_empty_i  (q_empty),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .pixel_o    (pixel_o),
    .line_done_o(line_done_o)
  );

endmodule

// ===== sv/srs_front.sv =====
module srs_front #(
  parameter int unsigned OutWidth = 320
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic               push_i,
  input  logic               q_full_i,
  input  logic [15:0]        word15_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic               line_end_i,
  output logic               q_wr_o,
  output srs_pkg::srs_entry_t q_entry_o
);

  localparam int unsigned OcW = $clog2(OutWidth + 1);
  localparam int unsigned LeadSkip = 4;
  localparam logic [4:0] Mod18Init = 5'(18 - LeadSkip);
  localparam logic [9:0] PosMax = 10'd1023;

  typedef enum logic [2:0] {
    W256 = 3'd0,
    W320 = 3'd1,
    W368 = 3'd2,
    W384 = 3'd3,
    W512 = 3'd4,
    W640 = 3'd5
  } width_mode_e;

  logic [2:0]     width_mode_q;
  logic           color_mode_q;
  logic [9:0]     pos_q, pos_d;
  logic [3:0]     mod12_q, mod12_d;
  logic [4:0]     mod18_q, mod18_d;
  logic [OcW-1:0] oc_q, oc_d;

  logic           accept;
  logic [1:0]     copies;
  logic           emit_any;
  logic           emit_two;
  logic [15:0]    colour;

  assign accept = push_i && !q_full_i;

  always_comb begin
    if (color_mode_q) begin
      colour = {red_i[7:3], green_i[7:2], blue_i[7:3]};
    end else begin
      colour = {word15_i[4:0], word15_i[9:5], 1'b0, word15_i[14:10]};
    end
  end

  always_comb begin
    copies = 2'd0;
    case (width_mode_e'(width_mode_q))
      W256: copies = (pos_q[2:0] inside {3'd1, 3'd5}) ? 2'd2 : 2'd1;
      W320: copies = 2'd1;
      W368: begin
        if (pos_q < 10'(LeadSkip)) begin
          copies = 2'd0;
        end else begin
          copies = (mod18_q inside {5'd8, 5'd17}) ? 2'd0 : 2'd1;
        end
      end
      W384: copies = (mod12_q inside {4'd5, 4'd11}) ? 2'd0 : 2'd1;
      W512: copies = (pos_q[2:0] inside {3'd0, 3'd1, 3'd3, 3'd4, 3'd6}) ? 2'd1 : 2'd0;
      W640: copies = pos_q[0] ? 2'd0 : 2'd1;
      default: copies = 2'd0;
    endcase
  end

  assign emit_any = (copies != 2'd0) && (oc_q < OcW'(OutWidth));
  assign emit_two = (copies == 2'd2) && (oc_q < OcW'(OutWidth - 1));

  assign q_wr_o                = accept && emit_any;
  assign q_entry_o.pixel       = colour;
  assign q_entry_o.twice       = emit_two;
  assign q_entry_o.done_first  = (oc_q == OcW'(OutWidth - 1));
  assign q_entry_o.done_second = (oc_q == OcW'(OutWidth - 2));

  always_comb begin
    pos_d   = pos_q;
    mod12_d = mod12_q;
    mod18_d = mod18_q;
    oc_d    = oc_q;
    if (accept) begin
      if (line_end_i) begin
        pos_d   = '0;
        mod12_d = '0;
        mod18_d = Mod18Init;
        oc_d    = '0;
      end else begin
        if (pos_q != PosMax) begin
          pos_d   = pos_q + 10'd1;
          mod12_d = (mod12_q == 4'd11) ? 4'd0 : mod12_q + 4'd1;
          mod18_d = (mod18_q == 5'd17) ? 5'd0 : mod18_q + 5'd1;
        end
        if (emit_two) begin
          oc_d = oc_q + OcW'(2);
        end else if (emit_any) begin
          oc_d = oc_q + OcW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_mode_q <= 3'(W320);
      color_mode_q <= 1'b0;
      pos_q        <= '0;
      mod12_q      <= '0;
      mod18_q      <= Mod18Init;
      oc_q         <= '0;
    end else begin
      if (cfg_we_i && (cfg_addr_i == srs_pkg::CfgWidthMode)) begin
        width_mode_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_addr_i == srs_pkg::CfgColorMode)) begin
        color_mode_q <= cfg_wdata_i[0];
      end
      pos_q   <= pos_d;
      mod12_q <= mod12_d;
      mod18_q <= mod18_d;
      oc_q    <= oc_d;
    end
  end

  a_oc_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    oc_q <= OcW'(OutWidth))
    else $error("output count beyond line width");

  a_line_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && line_end_i) |=> (pos_q == '0) && (oc_q == '0))
    else $error("counters not restarted after line end");

endmodule

// ===== sv/srs_queue.sv =====
module srs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  srs_pkg::srs_entry_t wr_entry_i,
  input  logic                rd_i,
  output srs_pkg::srs_entry_t rd_entry_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned Depth = srs_pkg::QDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  srs_pkg::srs_entry_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr;
  logic            do_rd;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && !empty_o;
  assign rd_entry_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_entry_i;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_cnt_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("queue count did not grow on write");

endmodule

// ===== sv/srs_back.sv =====
module srs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srs_pkg::srs_entry_t q_entry_i,
  input  logic                q_empty_i,
  output logic                q_rd_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [15:0]         pixel_o,
  output logic                line_done_o
);

  logic        valid_q, valid_d;
  logic        done_q, done_d;
  logic        sec_pending_q, sec_pending_d;
  logic        sec_done_q, sec_done_d;
  logic [15:0] pixel_q;
  logic        load;
  logic        take_new;

  assign load     = !valid_q || pop_i;
  assign take_new = load && !sec_pending_q && !q_empty_i;
  assign q_rd_o   = take_new;

  assign empty_o     = !valid_q;
  assign pixel_o     = pixel_q;
  assign line_done_o = done_q;

  always_comb begin
    valid_d       = valid_q;
    done_d        = done_q;
    sec_pending_d = sec_pending_q;
    sec_done_d    = sec_done_q;
    if (load) begin
      if (sec_pending_q) begin
        valid_d       = 1'b1;
        done_d        = sec_done_q;
        sec_pending_d = 1'b0;
      end else if (!q_empty_i) begin
        valid_d       = 1'b1;
        done_d        = q_entry_i.done_first;
        sec_pending_d = q_entry_i.twice;
        sec_done_d    = q_entry_i.done_second;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= 1'b0;
      done_q        <= 1'b0;
      sec_pending_q <= 1'b0;
      sec_done_q    <= 1'b0;
    end else begin
      valid_q       <= valid_d;
      done_q        <= done_d;
      sec_pending_q <= sec_pending_d;
      sec_done_q    <= sec_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_new) begin
      pixel_q <= q_entry_i.pixel;
    end
  end

  a_sec_needs_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_pending_q |-> valid_q)
    else $error("second copy pending without a first copy shown");

  a_sec_no_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_pending_q |-> !q_rd_o)
    else $error("queue read while a second copy is pending");

endmodule

// ===== tb/scanline_pixel_rescaler_tb.sv =====
module scanline_pixel_rescaler_tb;

  localparam int unsigned OutW        = 320;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 400000;

  localparam logic [2:0] WmW256 = 3'd0;
  localparam logic [2:0] WmW320 = 3'd1;
  localparam logic [2:0] WmW368 = 3'd2;
  localparam logic [2:0] WmW384 = 3'd3;
  localparam logic [2:0] WmW512 = 3'd4;
  localparam logic [2:0] WmW640 = 3'd5;
  localparam logic [2:0] WmBad6 = 3'd6;
  localparam logic [2:0] WmBad7 = 3'd7;

  localparam logic CmBgr15 = 1'b0;
  localparam logic CmRgb24 = 1'b1;

  typedef struct packed {
    logic [15:0] word15;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        line_end;
  } src_pixel_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic        line_done;
  } out_pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [2:0]  cfg_wdata_i;
  logic        push;
  logic        full;
  logic [15:0] word15_i;
  logic [7:0]  red_i;
  logic [7:0]  green_i;
  logic [7:0]  blue_i;
  logic        line_end_i;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] pixel_o;
  logic        line_done_o;

  logic [2:0]  wm_model = WmW320;
  logic        cm_model = CmBgr15;
  logic [9:0]  line_pos = '0;
  logic [8:0]  line_outs = '0;

  out_pixel_t  expected_pixels[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  scanline_pixel_rescaler #(
    .OutWidth(OutW)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .word15_i   (word15_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .line_end_i (line_end_i),
    .empty      (empty),
    .pop        (pop),
    .pixel_o    (pixel_o),
    .line_done_o(line_done_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("scanline_pixel_rescaler_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) pop <= rst_ni && ($urandom_range(99) >= recv_stall_pct);

  always @(negedge clk_i) begin
    if (rst_ni && pop && !empty) check_result();
  end

  function automatic int unsigned copy_count(input logic [9:0] p);
    int unsigned m8;
    int unsigned m12;
    int unsigned m18;
    m8  = p % 8;
    m12 = p % 12;
    m18 = (p - 4) % 18;
    case (wm_model)
      WmW256: return (m8 == 1 || m8 == 5) ? 2 : 1;
      WmW320: return 1;
      WmW368: return (p < 4 || m18 == 8 || m18 == 17) ? 0 : 1;
      WmW384: return (m12 == 5 || m12 == 11) ? 0 : 1;
      WmW512: return (m8 == 0 || m8 == 1 || m8 == 3 || m8 == 4 || m8 == 6) ? 1 : 0;
      WmW640: return p[0] ? 0 : 1;
      default: return 0;
    endcase
  endfunction

  task automatic predict_pixel(input src_pixel_t px);
    logic [15:0] colour;
    int unsigned n;
    out_pixel_t  res;
    if (cm_model == CmRgb24) colour = {px.red[7:3], px.green[7:2], px.blue[7:3]};
    else colour = {px.word15[4:0], px.word15[9:5], 1'b0, px.word15[14:10]};
    n = copy_count(line_pos);
    for (int unsigned k = 0; k < n; k++) begin
      if (line_outs < OutW) begin
        line_outs = line_outs + 9'd1;
        res.pixel = colour;
        res.line_done = (line_outs == OutW);
        expected_pixels.push_back(res);
      end
    end
    if (line_pos != 10'd1023) line_pos = line_pos + 10'd1;
    if (px.line_end) begin
      line_pos = '0;
      line_outs = '0;
    end
  endtask

  task automatic check_result();
    out_pixel_t want;
    if (expected_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: pixel %h line_done %b", pixel_o, line_done_o);
    end else begin
      want = expected_pixels.pop_front();
      if (want.pixel !== pixel_o || want.line_done !== line_done_o) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected pixel %h line_done %b, got pixel %h line_done %b",
                   want.pixel, want.line_done, pixel_o, line_done_o);
      end
    end
  endtask

  function automatic src_pixel_t make_pixel(input logic [15:0] w, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic le);
    src_pixel_t px;
    px.word15 = w;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.line_end = le;
    return px;
  endfunction

  function automatic src_pixel_t rand_pixel(input logic le);
    return make_pixel(16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)),
                      8'($urandom_range(8'hFF)), 8'($urandom_range(8'hFF)), le);
  endfunction

  function automatic logic [2:0] pick_width();
    if ($urandom_range(9) == 0) return 3'($urandom_range(WmBad7, WmBad6));
    return 3'($urandom_range(WmW640, WmW256));
  endfunction

  // Leaves push high; callers lower it only when the sender goes idle.
  task automatic send_pixel(input src_pixel_t px);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    word15_i   <= px.word15;
    red_i      <= px.red;
    green_i    <= px.green;
    blue_i     <= px.blue;
    line_end_i <= px.line_end;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end
    predict_pixel(px);
    items_sent++;
  endtask

  task automatic send_line(input int unsigned len, input bit terminate);
    for (int unsigned i = 0; i < len; i++)
      send_pixel(rand_pixel(terminate && (i == len - 1)));
  endtask

  // Keep pushing until the line is full, then up to six dropped items and the line end.
  task automatic send_full_line();
    int unsigned extra;
    extra = $urandom_range(6);
    while (line_outs != OutW && line_pos != 10'd1023 && wm_model <= WmW640)
      send_pixel(rand_pixel(1'b0));
    repeat (extra) send_pixel(rand_pixel(1'b0));
    send_pixel(rand_pixel(1'b1));
  endtask

  task automatic drain_block();
    push <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [2:0] wm, input logic cm);
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= srs_pkg::CfgWidthMode;
    cfg_wdata_i <= wm;
    @(posedge clk_i);
    wm_model = wm;
    cfg_addr_i  <= srs_pkg::CfgColorMode;
    cfg_wdata_i <= {2'b00, cm};
    @(posedge clk_i);
    cm_model = cm;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_line(2, 1'b1);
  endtask

  task automatic test_colour_packing();
    set_config(WmW320, CmBgr15);
    send_pixel(make_pixel(16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(make_pixel(16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(16'h7C00, 8'hAA, 8'h55, 8'hAA, 1'b0));
    send_pixel(make_pixel(16'h83FF, 8'h55, 8'hAA, 8'h55, 1'b1));
    set_config(WmW320, CmRgb24);
    send_pixel(make_pixel(16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(make_pixel(16'h5555, 8'h07, 8'h03, 8'h07, 1'b0));
    send_pixel(make_pixel(16'hAAAA, 8'hF8, 8'hFC, 8'hF8, 1'b1));
  endtask

  task automatic test_width_patterns();
    recv_stall_pct = 30;
    for (int unsigned wm = WmW256; wm <= WmBad7; wm++) begin
      set_config(wm[2:0], wm[0]);
      send_line(2, 1'b1);
    end
  endtask

  // Two items at width 640 offset the count so a doubled pixel lands on the last slot.
  task automatic test_double_at_limit();
    send_idle_pct = 20;
    recv_stall_pct = 20;
    set_config(WmW640, CmBgr15);
    send_line(2, 1'b0);
    set_config(WmW256, CmBgr15);
    send_full_line();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned item_goal, input logic [2:0] wm,
                                     input logic cm);
    int unsigned start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    set_config(wm, cm);
    start = items_sent;
    while (items_sent - start < item_goal) begin
      case ($urandom_range(9))
        0: set_config(pick_width(), 1'($urandom_range(1)));
        1: drain_block();
        2: send_line($urandom_range(12, 1), 1'b0);
        default: send_line($urandom_range(48, 1), 1'b1);
      endcase
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = srs_pkg::CfgWidthMode;
    cfg_wdata_i = '0;
    push        = 1'b0;
    word15_i    = '0;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    line_end_i  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_colour_packing();
    test_width_patterns();
    test_double_at_limit();
    test_random_traffic(0, 0, 130, WmW256, CmBgr15);
    test_random_traffic(56, 0, 130, WmW640, CmRgb24);
    test_random_traffic(0, 56, 130, WmW368, CmBgr15);
    test_random_traffic(17, 17, 130, WmW512, CmRgb24);

    drain_block();
    if (mismatches == 0) begin
      $display("scanline_pixel_rescaler_tb passed");
    end else begin
      $display("scanline_pixel_rescaler_tb failed");
    end
    $finish;
  end

endmodule
